// ===== sv/fcds_pkg.sv =====
// ----------------------------------------------------------------------------
// fcds_pkg
// Shared types, constants and small arithmetic helpers for the same-frame
// coding overlap block.
// ----------------------------------------------------------------------------
package fcds_pkg;

   // field width of coordinates, sizes and counts
   localparam int COORD_W = 31;

   // saturation value of coordinate-wide counters
   localparam logic [COORD_W-1:0] COORD_MAX = 31'h7FFF_FFFF;

   // reset value of the minimum overlap register
   localparam logic [COORD_W-1:0] MIN_OVERLAP_RESET = 31'd30;

   // residue mod 3 of a saturated counter
   localparam logic [1:0] SAT_MOD3 = 2'd1;

   // one stored reference interval with its frame
   typedef struct packed {
      logic [COORD_W-1:0] lo;
      logic [COORD_W-1:0] hi;
      logic [1:0]         phase;
   } ref_entry_type;

   // query block traveling down the cell chain
   typedef struct packed {
      logic [COORD_W-1:0] lo;
      logic [COORD_W-1:0] hi;
      logic [1:0]         phase;
      logic               coding;
      logic               last;
      logic               drop;
      logic [COORD_W-1:0] sum;
      logic [COORD_W-1:0] pend;
   } token_type;

   // saturating add of two coordinate-wide values
   function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
      logic [COORD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COORD_W] ? COORD_MAX : s[COORD_W-1:0];
   endfunction

   // residue mod 3: base-4 digits each count 1 mod 3, fold the digit sums
   function automatic logic [1:0] mod3(input logic [COORD_W-1:0] v);
      logic [31:0] w;
      logic [3:0]  q [4];
      logic [5:0]  s1;
      logic [3:0]  s2;
      logic [2:0]  s3;
      logic [1:0]  r;
      w  = {1'b0, v};
      // digit sums in groups of four, then across the groups
      for (int g = 0; g < 4; g++) begin
         q[g] = ({2'd0, w[8*g +: 2]} + {2'd0, w[8*g+2 +: 2]})
              + ({2'd0, w[8*g+4 +: 2]} + {2'd0, w[8*g+6 +: 2]});
      end
      s1 = ({2'd0, q[0]} + {2'd0, q[1]}) + ({2'd0, q[2]} + {2'd0, q[3]});
      s2 = {2'd0, s1[1:0]} + {2'd0, s1[3:2]} + {2'd0, s1[5:4]};
      s3 = {1'b0, s2[1:0]} + {1'b0, s2[3:2]};
      case (s3)
         3'd0, 3'd3, 3'd6: r = 2'd0;
         3'd1, 3'd4, 3'd7: r = 2'd1;
         3'd2, 3'd5:       r = 2'd2;
         default:          r = 2'd0;
      endcase
      return r;
   endfunction

   // (a - b) mod 3 for residues
   function automatic logic [1:0] sub_mod3(input logic [1:0] a, input logic [1:0] b);
      logic [2:0] t;
      t = {1'b0, a} + 3'd3 - {1'b0, b};
      return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
   endfunction

   // (a + b) mod 3 for residues
   function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] b);
      logic [2:0] t;
      t = {1'b0, a} + {1'b0, b};
      return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
   endfunction

endpackage

// ===== sv/frame_aware_cds_overlap.sv =====
// ----------------------------------------------------------------------------
// frame_aware_cds_overlap
// Same-frame coding overlap of a reference and a query transcript.
// ----------------------------------------------------------------------------
// One exon block is taken per cycle unless a stall or a reference hazard
// holds the front end. Blocks pass a four-stage front end that clips them
// to the coding span and assigns the frame, then each query block walks a
// chain of MAX_BLOCKS interval cells, one cell per cycle while the chain
// advances, so many queries are in the chain at once. A coding reference
// block that follows queries still in the chain waits at the end of the
// front end until the chain has drained, since the cell store is rewritten
// only with no query inside it. A result that is not taken holds back the
// chain only once another last block reaches the chain's end.
// ----------------------------------------------------------------------------
module frame_aware_cds_overlap #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_func,
   input  logic [fcds_pkg::COORD_W-1:0] req_tx_start,
   input  logic [fcds_pkg::COORD_W-1:0] req_block_offset,
   input  logic [fcds_pkg::COORD_W-1:0] req_block_size,
   input  logic [fcds_pkg::COORD_W-1:0] req_cds_start,
   input  logic [fcds_pkg::COORD_W-1:0] req_cds_end,
   input  logic                         req_is_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [fcds_pkg::COORD_W-1:0] rsp_overlap_bases,
   output logic                         rsp_meets_min,
   output logic                         rsp_ref_overflow,
   input  logic                         csr_wr_en,
   input  logic [fcds_pkg::COORD_W-1:0] csr_wr_data
);

   localparam int UW = $clog2(MAX_BLOCKS + 1);
   localparam int IW = $clog2(MAX_BLOCKS + 4);

   logic [fcds_pkg::COORD_W-1:0] min_ff;
   logic [IW-1:0]                inflight_ff, inflight_in;

   logic                    adv;
   logic                    consume;
   logic                    chain_idle;
   logic                    wr_en;
   logic [UW-1:0]           wr_idx;
   fcds_pkg::ref_entry_type wr_entry;

   logic                chain_valid [0:MAX_BLOCKS];
   fcds_pkg::token_type chain_tok   [0:MAX_BLOCKS];
   logic [UW-1:0]       chain_used  [0:MAX_BLOCKS];

   // minimum overlap register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= fcds_pkg::MIN_OVERLAP_RESET;
      end else if (csr_wr_en) begin
         min_ff <= csr_wr_data;
      end
   end

   // queries between issue and the end of the chain
   assign inflight_in = inflight_ff + IW'(chain_valid[0]) - IW'(consume);
   assign chain_idle  = inflight_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // clipping, framing and reference store control
   fcds_front #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_tx_start     (req_tx_start),
      .req_block_offset (req_block_offset),
      .req_block_size   (req_block_size),
      .req_cds_start    (req_cds_start),
      .req_cds_end      (req_cds_end),
      .req_is_last      (req_is_last),
      .adv              (adv),
      .chain_idle       (chain_idle),
      .issue_valid      (chain_valid[0]),
      .issue_tok        (chain_tok[0]),
      .issue_used       (chain_used[0]),
      .wr_en            (wr_en),
      .wr_idx           (wr_idx),
      .wr_entry         (wr_entry)
   );

   // interval cell chain
   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      fcds_cell #(
         .MAX_BLOCKS (MAX_BLOCKS),
         .CELL_INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .wr_en     (wr_en),
         .wr_idx    (wr_idx),
         .wr_entry  (wr_entry),
         .in_valid  (chain_valid[i]),
         .in_tok    (chain_tok[i]),
         .in_used   (chain_used[i]),
         .out_valid (chain_valid[i+1]),
         .out_tok   (chain_tok[i+1]),
         .out_used  (chain_used[i+1])
      );
   end

   // total and result register
   fcds_tail u_tail (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (chain_valid[MAX_BLOCKS]),
      .in_tok       (chain_tok[MAX_BLOCKS]),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_overlap  (rsp_overlap_bases),
      .rsp_overflow (rsp_ref_overflow),
      .adv          (adv),
      .consume      (consume)
   );

   // compare against the current minimum
   assign rsp_meets_min = rsp_overlap_bases >= min_ff;

endmodule

// ===== sv/fcds_front.sv =====
// ----------------------------------------------------------------------------
// fcds_front
// Input pipeline: clips each block to its coding span, works out its frame,
// stores reference intervals and issues query blocks into the cell chain.
// ----------------------------------------------------------------------------
module fcds_front #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_func,
   input  logic [fcds_pkg::COORD_W-1:0]   req_tx_start,
   input  logic [fcds_pkg::COORD_W-1:0]   req_block_offset,
   input  logic [fcds_pkg::COORD_W-1:0]   req_block_size,
   input  logic [fcds_pkg::COORD_W-1:0]   req_cds_start,
   input  logic [fcds_pkg::COORD_W-1:0]   req_cds_end,
   input  logic                           req_is_last,
   input  logic                           adv,
   input  logic                           chain_idle,
   output logic                           issue_valid,
   output fcds_pkg::token_type            issue_tok,
   output logic [$clog2(MAX_BLOCKS+1)-1:0] issue_used,
   output logic                           wr_en,
   output logic [$clog2(MAX_BLOCKS+1)-1:0] wr_idx,
   output fcds_pkg::ref_entry_type        wr_entry
);

   localparam int UW = $clog2(MAX_BLOCKS + 1);
   localparam int CW = fcds_pkg::COORD_W;

   logic fe;
   logic hazard;
   logic commit;

   // stage 1: block start
   logic          s1_valid_ff;
   logic [CW:0]   s1_start_ff;
   logic [CW-1:0] s1_size_ff;
   logic [CW-1:0] s1_cs_ff;
   logic [CW-1:0] s1_ce_ff;
   logic          s1_func_ff;
   logic          s1_last_ff;

   // stage 2: clipped interval
   logic [CW+1:0] s2_end;
   logic [CW:0]   s2_lo;
   logic [CW+1:0] s2_hi;
   logic          s2_valid_ff;
   logic [CW-1:0] s2_lo_ff;
   logic [CW-1:0] s2_hi_ff;
   logic          s2_coding_ff;
   logic          s2_func_ff;
   logic          s2_last_ff;

   // stage 3: length and start residue
   logic          s3_valid_ff;
   logic [CW-1:0] s3_lo_ff;
   logic [CW-1:0] s3_hi_ff;
   logic [CW-1:0] s3_len_ff;
   logic [1:0]    s3_lo_m3_ff;
   logic          s3_coding_ff;
   logic          s3_func_ff;
   logic          s3_last_ff;

   // stage 4: length residue
   logic          s4_valid_ff;
   logic [CW-1:0] s4_lo_ff;
   logic [CW-1:0] s4_hi_ff;
   logic [CW-1:0] s4_len_ff;
   logic [1:0]    s4_lo_m3_ff;
   logic [1:0]    s4_len_m3_ff;
   logic          s4_coding_ff;
   logic          s4_func_ff;
   logic          s4_last_ff;

   // transcript state
   logic          querying_ff, querying_in;
   logic [CW-1:0] seen_ff, seen_in;
   logic [1:0]    seen_m3_ff, seen_m3_in;
   logic [UW-1:0] used_ff, used_in;
   logic          dropped_ff, dropped_in;

   // commit helpers
   logic          q_start;
   logic [CW-1:0] base_seen;
   logic [1:0]    base_m3;
   logic [1:0]    phase;
   logic [CW:0]   seen_sum;
   logic [CW-1:0] seen_add;
   logic [1:0]    m3_add;
   logic          full;

   // a stored reference must not change under queries still in the chain
   assign hazard    = s4_valid_ff && !s4_func_ff && !querying_ff && s4_coding_ff
                      && !chain_idle;
   assign fe        = adv && !hazard;
   assign commit    = fe && s4_valid_ff;
   assign req_ready = fe;

   // stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (fe) begin
         s1_valid_ff <= req_valid;
      end
      if (fe) begin
         s1_start_ff <= {1'b0, req_tx_start} + {1'b0, req_block_offset};
         s1_size_ff  <= req_block_size;
         s1_cs_ff    <= req_cds_start;
         s1_ce_ff    <= req_cds_end;
         s1_func_ff  <= req_func;
         s1_last_ff  <= req_is_last;
      end
   end

   // clip to the coding span
   always_comb begin
      s2_end = {1'b0, s1_start_ff} + {2'b00, s1_size_ff};
      s2_lo  = (s1_start_ff < {1'b0, s1_cs_ff}) ? {1'b0, s1_cs_ff} : s1_start_ff;
      s2_hi  = (s2_end > {2'b00, s1_ce_ff}) ? {2'b00, s1_ce_ff} : s2_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (fe) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (fe) begin
         s2_lo_ff     <= s2_lo[CW-1:0];
         s2_hi_ff     <= s2_hi[CW-1:0];
         s2_coding_ff <= {1'b0, s2_lo} < s2_hi;
         s2_func_ff   <= s1_func_ff;
         s2_last_ff   <= s1_last_ff;
      end
   end

   // stage 3
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (fe) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (fe) begin
         s3_lo_ff     <= s2_lo_ff;
         s3_hi_ff     <= s2_hi_ff;
         s3_len_ff    <= s2_hi_ff - s2_lo_ff;
         s3_lo_m3_ff  <= fcds_pkg::mod3(s2_lo_ff);
         s3_coding_ff <= s2_coding_ff;
         s3_func_ff   <= s2_func_ff;
         s3_last_ff   <= s2_last_ff;
      end
   end

   // stage 4
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (fe) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (fe) begin
         s4_lo_ff     <= s3_lo_ff;
         s4_hi_ff     <= s3_hi_ff;
         s4_len_ff    <= s3_len_ff;
         s4_lo_m3_ff  <= s3_lo_m3_ff;
         s4_len_m3_ff <= fcds_pkg::mod3(s3_len_ff);
         s4_coding_ff <= s3_coding_ff;
         s4_func_ff   <= s3_func_ff;
         s4_last_ff   <= s3_last_ff;
      end
   end

   // frame and coding count update
   always_comb begin
      q_start   = s4_func_ff && !querying_ff;
      base_seen = q_start ? '0 : seen_ff;
      base_m3   = q_start ? 2'd0 : seen_m3_ff;
      phase     = fcds_pkg::sub_mod3(s4_lo_m3_ff, base_m3);
      seen_sum  = {1'b0, base_seen} + {1'b0, s4_len_ff};
      seen_add  = seen_sum[CW] ? fcds_pkg::COORD_MAX : seen_sum[CW-1:0];
      m3_add    = seen_sum[CW] ? fcds_pkg::SAT_MOD3
                               : fcds_pkg::add_mod3(base_m3, s4_len_m3_ff);
      full      = used_ff == UW'(MAX_BLOCKS);
   end

   // commit of the block in stage 4
   always_comb begin
      querying_in = querying_ff;
      seen_in     = seen_ff;
      seen_m3_in  = seen_m3_ff;
      used_in     = used_ff;
      dropped_in  = dropped_ff;
      wr_en       = 1'b0;
      if (commit) begin
         if (!s4_func_ff) begin
            // reference blocks count only before the query starts
            if (!querying_ff) begin
               if (s4_coding_ff) begin
                  if (!full) begin
                     wr_en   = 1'b1;
                     used_in = used_ff + UW'(1);
                  end else begin
                     dropped_in = 1'b1;
                  end
                  seen_in    = seen_add;
                  seen_m3_in = m3_add;
               end
               if (s4_last_ff) begin
                  seen_in    = '0;
                  seen_m3_in = 2'd0;
               end
            end
         end else begin
            querying_in = 1'b1;
            seen_in     = base_seen;
            seen_m3_in  = base_m3;
            if (s4_coding_ff) begin
               seen_in    = seen_add;
               seen_m3_in = m3_add;
            end
            // last query block clears for the next pair
            if (s4_last_ff) begin
               querying_in = 1'b0;
               seen_in     = '0;
               seen_m3_in  = 2'd0;
               used_in     = '0;
               dropped_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         querying_ff <= 1'b0;
         seen_ff     <= '0;
         seen_m3_ff  <= 2'd0;
         used_ff     <= '0;
         dropped_ff  <= 1'b0;
      end else begin
         querying_ff <= querying_in;
         seen_ff     <= seen_in;
         seen_m3_ff  <= seen_m3_in;
         used_ff     <= used_in;
         dropped_ff  <= dropped_in;
      end
   end

   // reference store write and query issue
   always_comb begin
      wr_idx             = used_ff;
      wr_entry.lo        = s4_lo_ff;
      wr_entry.hi        = s4_hi_ff;
      wr_entry.phase     = phase;
      issue_valid        = commit && s4_func_ff;
      issue_used         = used_ff;
      issue_tok.lo       = s4_lo_ff;
      issue_tok.hi       = s4_hi_ff;
      issue_tok.phase    = phase;
      issue_tok.coding   = s4_coding_ff;
      issue_tok.last     = s4_last_ff;
      issue_tok.drop     = dropped_ff;
      issue_tok.sum      = '0;
      issue_tok.pend     = '0;
   end

endmodule

// ===== sv/fcds_cell.sv =====
// ----------------------------------------------------------------------------
// fcds_cell
// One interval cell: holds a reference interval with its frame, adds the
// overlap pending from the previous cell and works out its own overlap
// with the passing query block.
// ----------------------------------------------------------------------------
module fcds_cell #(
   parameter int MAX_BLOCKS = 64,
   parameter int CELL_INDEX = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            wr_en,
   input  logic [$clog2(MAX_BLOCKS+1)-1:0] wr_idx,
   input  fcds_pkg::ref_entry_type         wr_entry,
   input  logic                            in_valid,
   input  fcds_pkg::token_type             in_tok,
   input  logic [$clog2(MAX_BLOCKS+1)-1:0] in_used,
   output logic                            out_valid,
   output fcds_pkg::token_type             out_tok,
   output logic [$clog2(MAX_BLOCKS+1)-1:0] out_used
);

   localparam int UW = $clog2(MAX_BLOCKS + 1);
   localparam int CW = fcds_pkg::COORD_W;

   fcds_pkg::ref_entry_type ent_ff;
   logic                    out_valid_ff;
   fcds_pkg::token_type     out_tok_ff;
   fcds_pkg::token_type     out_tok_in;
   logic [UW-1:0]           out_used_ff;

   logic [CW-1:0] ov_lo;
   logic [CW-1:0] ov_hi;
   logic          hit;
   logic [CW-1:0] pend;

   // stored interval
   always_ff @(posedge clock) begin
      if (wr_en && wr_idx == UW'(CELL_INDEX)) begin
         ent_ff <= wr_entry;
      end
   end

   // overlap with this cell's interval, only for entries in use
   always_comb begin
      ov_lo = (ent_ff.lo > in_tok.lo) ? ent_ff.lo : in_tok.lo;
      ov_hi = (ent_ff.hi < in_tok.hi) ? ent_ff.hi : in_tok.hi;
      hit   = in_valid && in_tok.coding && (UW'(CELL_INDEX) < in_used)
              && ent_ff.phase == in_tok.phase && ov_lo < ov_hi;
      pend  = hit ? (ov_hi - ov_lo) : '0;
      out_tok_in      = in_tok;
      out_tok_in.sum  = fcds_pkg::sat_add(in_tok.sum, in_tok.pend);
      out_tok_in.pend = pend;
   end

   // hand the query to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= in_valid;
      end
      if (adv) begin
         out_tok_ff  <= out_tok_in;
         out_used_ff <= in_used;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_tok   = out_tok_ff;
   assign out_used  = out_used_ff;

endmodule

// ===== sv/fcds_tail.sv =====
// ----------------------------------------------------------------------------
// fcds_tail
// End of the cell chain: folds each query's overlap into the running total
// and holds the result of the last query block until it is taken.
// ----------------------------------------------------------------------------
module fcds_tail (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  fcds_pkg::token_type          in_tok,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [fcds_pkg::COORD_W-1:0] rsp_overlap,
   output logic                         rsp_overflow,
   output logic                         adv,
   output logic                         consume
);

   localparam int CW = fcds_pkg::COORD_W;

   logic          t_valid_ff;
   logic [CW-1:0] t_total_ff;
   logic          t_last_ff;
   logic          t_drop_ff;
   logic [CW-1:0] acc_ff;
   logic [CW-1:0] acc_next;
   logic          rsp_valid_ff;
   logic [CW-1:0] rsp_overlap_ff;
   logic          rsp_overflow_ff;

   // stall only when a final total meets a result not yet taken
   assign adv      = !(t_valid_ff && t_last_ff && rsp_valid_ff && !rsp_ready);
   assign consume  = adv && t_valid_ff;
   assign acc_next = fcds_pkg::sat_add(acc_ff, t_total_ff);

   // last pending overlap of the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
      end else if (adv) begin
         t_valid_ff <= in_valid;
      end
      if (adv) begin
         t_total_ff <= fcds_pkg::sat_add(in_tok.sum, in_tok.pend);
         t_last_ff  <= in_tok.last;
         t_drop_ff  <= in_tok.drop;
      end
   end

   // running total and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (consume) begin
            acc_ff <= t_last_ff ? '0 : acc_next;
         end
         if (consume && t_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (consume && t_last_ff) begin
         rsp_overlap_ff  <= acc_next;
         rsp_overflow_ff <= t_drop_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_overlap  = rsp_overlap_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

// ===== sv/fcds_checker.sv =====
// ----------------------------------------------------------------------------
// fcds_checker
// Port-level checks of the result channel and the minimum overlap flag.
// ----------------------------------------------------------------------------
module fcds_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [fcds_pkg::COORD_W-1:0] rsp_overlap_bases,
   input logic                         rsp_meets_min,
   input logic                         rsp_ref_overflow,
   input logic                         csr_wr_en,
   input logic [fcds_pkg::COORD_W-1:0] csr_wr_data
);

   logic [fcds_pkg::COORD_W-1:0] min_shadow_ff;

   // shadow of the minimum overlap register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_shadow_ff <= fcds_pkg::MIN_OVERLAP_RESET;
      end else if (csr_wr_en) begin
         min_shadow_ff <= csr_wr_data;
      end
   end

   // a result waiting for transfer keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_overlap_bases)
                                  && $stable(rsp_ref_overflow))
      else $error("result changed while waiting for transfer");

   // flag agrees with the total and the configured minimum
   a_meets_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_meets_min == (rsp_overlap_bases >= min_shadow_ff))
      else $error("meets_min disagrees with overlap and minimum");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input is taken right after reset, the pipeline is empty
   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset && !rsp_valid |-> req_ready || !req_valid)
      else $error("input not ready after reset");

endmodule

bind frame_aware_cds_overlap fcds_checker u_fcds_checker (.*);

// ===== tb/frame_aware_cds_overlap_tb.sv =====
// ----------------------------------------------------------------------------
// frame_aware_cds_overlap_tb
// Self-checking bench for the same-frame coding overlap block. A scripted
// table of exon blocks comes first, then random reference/query pairs under
// several minimum-overlap settings. Results are checked field by field against
// scripted values or a bench model of clipping, framing and interval overlap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_aware_cds_overlap_tb;

   localparam int REF_SLOTS = 64;
   localparam int W = fcds_pkg::COORD_W;
   localparam longint unsigned COUNT_MAX = 64'h7FFF_FFFF;
   localparam int DRAIN_CYCLES = 2 * REF_SLOTS + 16;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DIR_ROWS = 22;
   localparam int LONG_HOLD = 800;

   // block kinds on req_func
   localparam logic FUNC_REF   = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [W-1:0] M31 = fcds_pkg::COORD_MAX;

   typedef struct packed {
      logic         func;
      logic [W-1:0] tx_start;
      logic [W-1:0] block_offset;
      logic [W-1:0] block_size;
      logic [W-1:0] cds_start;
      logic [W-1:0] cds_end;
      logic         is_last;
   } exon_block_type;

   typedef struct packed {
      logic [W-1:0] overlap_bases;
      logic         meets_min;
      logic         ref_overflow;
   } overlap_result_type;

   typedef struct packed {
      exon_block_type     blk;
      logic               typed;
      overlap_result_type res;
   } script_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   logic         req_func = 1'b0;
   logic [W-1:0] req_tx_start = '0;
   logic [W-1:0] req_block_offset = '0;
   logic [W-1:0] req_block_size = '0;
   logic [W-1:0] req_cds_start = '0;
   logic [W-1:0] req_cds_end = '0;
   logic         req_is_last = 1'b0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   logic [W-1:0] rsp_overlap_bases;
   logic         rsp_meets_min;
   logic         rsp_ref_overflow;
   logic         csr_wr_en = 1'b0;
   logic [W-1:0] csr_wr_data = '0;

   // model state
   longint unsigned slot_lo [REF_SLOTS];
   longint unsigned slot_hi [REF_SLOTS];
   logic [1:0]      slot_frame [REF_SLOTS];
   int unsigned     slots_filled = 0;
   longint unsigned coding_count = 0;
   longint unsigned overlap_sum = 0;
   bit              in_query = 1'b0;
   bit              slots_overflowed = 1'b0;
   longint unsigned min_overlap = 30;

   overlap_result_type overlap_expect_q [$];
   int unsigned        mismatches = 0;
   int unsigned        items_sent = 0;
   int unsigned        cycle_count = 0;
   int unsigned        hold_rsp_cycles = 0;
   bit                 steady = 1'b0;
   bit                 rush = 1'b0;

   frame_aware_cds_overlap #(
      .MAX_BLOCKS(REF_SLOTS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_tx_start     (req_tx_start),
      .req_block_offset (req_block_offset),
      .req_block_size   (req_block_size),
      .req_cds_start    (req_cds_start),
      .req_cds_end      (req_cds_end),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_overlap_bases(rsp_overlap_bases),
      .rsp_meets_min    (rsp_meets_min),
      .rsp_ref_overflow (rsp_ref_overflow),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // clock generation
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** frame_aware_cds_overlap: FAILED **");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   // true residue of (start - seen) mod 3
   function automatic logic [1:0] frame_of(input longint unsigned start,
                                           input longint unsigned seen);
      return 2'(((start % 3) + 3 - (seen % 3)) % 3);
   endfunction

   function automatic longint unsigned grow_count(input longint unsigned c,
                                                  input longint unsigned n);
      return (c + n > COUNT_MAX) ? COUNT_MAX : c + n;
   endfunction

   function automatic int unsigned draw_idle();
      return steady ? 0 : $urandom_range(0, 15);
   endfunction

   // advance the model by one accepted block, report a result if one is due
   task automatic apply_block(input exon_block_type b, output bit emits,
                              output overlap_result_type r);
      longint unsigned s, e, lo, hi, acc, a, z;
      logic [1:0]      fr;
      bit              coding;
      int unsigned     i;
      emits = 1'b0;
      r = '0;
      s = longint'(b.tx_start) + longint'(b.block_offset);
      e = s + longint'(b.block_size);
      if (s < longint'(b.cds_start)) s = longint'(b.cds_start);
      if (e > longint'(b.cds_end)) e = longint'(b.cds_end);
      coding = s < e;
      lo = s;
      hi = e;
      // reference side: store with frame, or drop once full
      if (b.func == FUNC_REF) begin
         if (in_query) return;
         if (coding) begin
            fr = frame_of(lo, coding_count);
            if (slots_filled < REF_SLOTS) begin
               slot_lo[slots_filled] = lo;
               slot_hi[slots_filled] = hi;
               slot_frame[slots_filled] = fr;
               slots_filled++;
            end else begin
               slots_overflowed = 1'b1;
            end
            coding_count = grow_count(coding_count, hi - lo);
         end
         if (b.is_last) coding_count = 0;
         return;
      end
      // query side: first block restarts the coding count
      if (!in_query) begin
         coding_count = 0;
         in_query = 1'b1;
      end
      if (coding) begin
         fr = frame_of(lo, coding_count);
         acc = overlap_sum;
         for (i = 0; i < slots_filled; i++) begin
            if (slot_frame[i] == fr) begin
               a = (slot_lo[i] > lo) ? slot_lo[i] : lo;
               z = (slot_hi[i] < hi) ? slot_hi[i] : hi;
               if (a < z) acc += z - a;
               if (acc > COUNT_MAX) acc = COUNT_MAX;
            end
         end
         overlap_sum = acc;
         coding_count = grow_count(coding_count, hi - lo);
      end
      if (b.is_last) begin
         emits = 1'b1;
         r.overlap_bases = W'(overlap_sum);
         r.meets_min = overlap_sum >= min_overlap;
         r.ref_overflow = slots_overflowed;
         slots_filled = 0;
         coding_count = 0;
         overlap_sum = 0;
         in_query = 1'b0;
         slots_overflowed = 1'b0;
      end
   endtask

   // offer one block, wait for its transfer, then log the expectation
   task automatic drive_block(input exon_block_type b, input bit typed,
                              input overlap_result_type typed_res);
      int unsigned        gap;
      bit                 emits;
      overlap_result_type predicted;
      if ($urandom_range(0, 23) == 0) steady = !steady;
      gap = rush ? 0 : draw_idle();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= b.func;
      req_tx_start     <= b.tx_start;
      req_block_offset <= b.block_offset;
      req_block_size   <= b.block_size;
      req_cds_start    <= b.cds_start;
      req_cds_end      <= b.cds_end;
      req_is_last      <= b.is_last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      apply_block(b, emits, predicted);
      if (typed && !emits)
         report_mismatch("scripted result on a block that yields none");
      if (emits)
         overlap_expect_q.push_back(typed ? typed_res : predicted);
   endtask

   // occasional stray blocks ahead of a well-formed one
   task automatic send_noisy(input exon_block_type b);
      exon_block_type     n;
      overlap_result_type none;
      none = '0;
      if ($urandom_range(0, 11) == 0) begin
         n.func         = 1'($urandom);
         n.tx_start     = W'($urandom);
         n.block_offset = W'($urandom);
         n.block_size   = W'($urandom);
         n.cds_start    = W'($urandom);
         n.cds_end      = W'($urandom);
         n.is_last      = 1'($urandom);
         drive_block(n, 1'b0, none);
      end
      if (b.func == FUNC_QUERY && $urandom_range(0, 9) == 0) begin
         n = b;
         n.func = FUNC_REF;
         n.is_last = 1'($urandom);
         drive_block(n, 1'b0, none);
      end
      drive_block(b, 1'b0, none);
   endtask

   // one reference transcript followed by one query transcript
   task automatic send_pair(input bit flood);
      exon_block_type b;
      int unsigned n_ref, n_qry, cursor, i;
      int unsigned ref_off [REF_SLOTS + 8];
      int unsigned ref_sz [REF_SLOTS + 8];
      bit          replay;
      b.tx_start  = W'($urandom_range(0, 32'h7FFF_FFFF - 300000));
      b.cds_start = b.tx_start + W'($urandom_range(0, 600));
      if (flood)
         b.cds_end = b.cds_start + W'(100000);
      else if ($urandom_range(0, 15) == 0)
         b.cds_end = b.cds_start - W'($urandom_range(0, 100));
      else
         b.cds_end = b.cds_start + W'($urandom_range(0, 30000));
      n_ref = flood ? $urandom_range(REF_SLOTS - 4, REF_SLOTS + 6) : $urandom_range(0, 6);
      cursor = 0;
      // reference exons, ascending and disjoint
      for (i = 0; i < n_ref; i++) begin
         b.func = FUNC_REF;
         if (flood) begin
            b.block_offset = W'(cursor + $urandom_range(0, 20));
            b.block_size   = W'($urandom_range(1, 60));
         end else begin
            b.block_offset = W'(cursor + $urandom_range(0, 300));
            b.block_size   = ($urandom_range(0, 9) == 0) ? '0 : W'($urandom_range(1, 400));
         end
         cursor = b.block_offset + b.block_size;
         ref_off[i] = b.block_offset;
         ref_sz[i] = b.block_size;
         b.is_last = (i == n_ref - 1) || ($urandom_range(0, 9) == 0);
         send_noisy(b);
      end
      // query exons, either replaying the reference layout or scattered
      replay = !flood && n_ref != 0 && $urandom_range(0, 1) == 1;
      n_qry = replay ? n_ref : $urandom_range(1, 6);
      for (i = 0; i < n_qry; i++) begin
         b.func = FUNC_QUERY;
         if (replay) begin
            b.block_offset = W'(ref_off[i] + (($urandom_range(0, 3) == 0) ?
                                              $urandom_range(0, 2) : 0));
            b.block_size = W'(ref_sz[i]);
         end else begin
            b.block_offset = W'($urandom_range(0, cursor + 300));
            b.block_size   = ($urandom_range(0, 9) == 0) ? '0 : W'($urandom_range(1, 400));
         end
         b.is_last = (i == n_qry - 1);
         send_noisy(b);
      end
   endtask

   // wait for every expected result, then for the pipeline to empty
   task automatic settle();
      while (overlap_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_overlap(input logic [W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      min_overlap = v;
   endtask

   task automatic run_phase(input int unsigned target, input bit with_flood);
      int unsigned first;
      bit          flood;
      first = items_sent;
      flood = with_flood;
      while (items_sent - first < target) begin
         send_pair(flood);
         flood = 1'b0;
      end
      req_valid <= 1'b0;
      settle();
   endtask

   function automatic script_row_type mk_row(
      input logic func, input logic [W-1:0] tx, input logic [W-1:0] off,
      input logic [W-1:0] sz, input logic [W-1:0] cs, input logic [W-1:0] ce,
      input logic last, input logic typed, input logic [W-1:0] ob,
      input logic mm, input logic ovf);
      script_row_type r;
      r.blk = '{func, tx, off, sz, cs, ce, last};
      r.typed = typed;
      r.res = '{ob, mm, ovf};
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      overlap_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (overlap_expect_q.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
         end else begin
            want = overlap_expect_q.pop_front();
            if (rsp_overlap_bases !== want.overlap_bases)
               report_mismatch($sformatf("overlap_bases got %0d want %0d",
                                         rsp_overlap_bases, want.overlap_bases));
            if (rsp_meets_min !== want.meets_min)
               report_mismatch($sformatf("meets_min got %b want %b",
                                         rsp_meets_min, want.meets_min));
            if (rsp_ref_overflow !== want.ref_overflow)
               report_mismatch($sformatf("ref_overflow got %b want %b",
                                         rsp_ref_overflow, want.ref_overflow));
         end
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin : receiver
      int unsigned pause;
      forever begin
         if (hold_rsp_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_rsp_cycles) @(posedge clock);
            hold_rsp_cycles = 0;
         end
         pause = draw_idle();
         if (pause != 0) begin
            rsp_ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock);
         while (!(rsp_valid && rsp_ready) && hold_rsp_cycles == 0);
      end
   end

   // stimulus
   initial begin : stimulus
      script_row_type script [DIR_ROWS];
      logic [W-1:0]   settings [5];
      int unsigned    k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty query right after reset, at the reset minimum of 30
      script[0]  = mk_row(FUNC_QUERY, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0);
      // two framed references, then a query matching both
      script[1]  = mk_row(FUNC_REF, 1000, 0, 100, 1000, 2000, 0, 0, 0, 0, 0);
      script[2]  = mk_row(FUNC_REF, 1000, 200, 50, 1000, 2000, 1, 0, 0, 0, 0);
      script[3]  = mk_row(FUNC_QUERY, 1000, 0, 100, 1000, 2000, 0, 0, 0, 0, 0);
      script[4]  = mk_row(FUNC_QUERY, 1000, 200, 50, 1000, 2000, 1, 1, 150, 1, 0);
      // all-ones coordinates clip to nothing
      script[5]  = mk_row(FUNC_REF, M31, M31, M31, 0, M31, 0, 0, 0, 0, 0);
      // full-range reference saturates the coding count
      script[6]  = mk_row(FUNC_REF, 0, 0, M31, 0, M31, 0, 0, 0, 0, 0);
      // count above start: frame wraps
      script[7]  = mk_row(FUNC_REF, 0, 0, 10, 0, M31, 0, 0, 0, 0, 0);
      // empty block whose last flag still ends the reference
      script[8]  = mk_row(FUNC_REF, 5, 0, 0, 0, 100, 1, 0, 0, 0, 0);
      script[9]  = mk_row(FUNC_QUERY, 0, 0, M31, 0, M31, 0, 0, 0, 0, 0);
      // reference during query is ignored, last flag included
      script[10] = mk_row(FUNC_REF, 0, 0, 10, 0, 100, 1, 0, 0, 0, 0);
      // accumulator saturates
      script[11] = mk_row(FUNC_QUERY, 0, 0, 10, 0, 100, 1, 1, M31, 1, 0);
      // empty last query on an empty store
      script[12] = mk_row(FUNC_QUERY, 50, 0, 10, 0, 40, 1, 1, 0, 0, 0);
      // inverted coding span
      script[13] = mk_row(FUNC_REF, 0, 0, 1000, 500, 100, 0, 0, 0, 0, 0);
      // clipping at both ends
      script[14] = mk_row(FUNC_REF, 10, 0, 20, 15, 25, 0, 0, 0, 0, 0);
      script[15] = mk_row(FUNC_REF, 40, 2, 9, 0, 1000, 1, 0, 0, 0, 0);
      script[16] = mk_row(FUNC_QUERY, 14, 0, 12, 0, 1000, 0, 0, 0, 0, 0);
      script[17] = mk_row(FUNC_QUERY, 40, 0, 20, 0, 1000, 1, 0, 0, 0, 0);
      // overlapping stored intervals each count
      script[18] = mk_row(FUNC_REF, 0, 0, 30, 0, 1000, 0, 0, 0, 0, 0);
      script[19] = mk_row(FUNC_REF, 30, 0, 30, 0, 1000, 0, 0, 0, 0, 0);
      script[20] = mk_row(FUNC_REF, 3, 0, 30, 0, 1000, 1, 0, 0, 0, 0);
      script[21] = mk_row(FUNC_QUERY, 0, 0, 40, 0, 1000, 1, 0, 0, 0, 0);

      for (k = 0; k < DIR_ROWS; k++)
         drive_block(script[k].blk, script[k].typed, script[k].res);
      req_valid <= 1'b0;
      settle();

      // random pairs under several minimum settings
      settings[0] = '0;
      settings[1] = M31;
      settings[2] = W'(1);
      settings[3] = W'($urandom_range(1, 3000));
      settings[4] = W'($urandom);
      for (k = 0; k < 5; k++) begin
         write_min_overlap(settings[k]);
         if (k == 2) begin
            rush = 1'b1;
            hold_rsp_cycles = LONG_HOLD;
         end
         run_phase((k == 2) ? 100 : 75, k == 1 || k == 3);
         rush = 1'b0;
      end

      if (mismatches == 0 && overlap_expect_q.size() == 0)
         $display("** frame_aware_cds_overlap: PASSED **");
      else
         $display("** frame_aware_cds_overlap: FAILED **");
      $finish;
   end

endmodule
